FILE: rtl/core/task_checkin_watchdog_assert.svh
// Assertion macros used by the watchdog top level.
`ifndef TASK_CHECKIN_WATCHDOG_ASSERT_SVH
`define TASK_CHECKIN_WATCHDOG_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

FILE: rtl/core/tcw_pkg.sv
// Types and constants of the task check-in watchdog.
package tcw_pkg;

    localparam int NUM_TASKS = 16;

    localparam int TASK_W    = 4;
    localparam int MASK_W    = 16;
    localparam int COUNT_W   = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    // Operation codes of a request.
    localparam logic OP_CHECKIN = 1'b0;
    localparam logic OP_PROCESS = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_MASK = 1'b1;

    localparam logic [MASK_W-1:0] REQ_MASK_RESET = '1;

    // Bits of the tasks that exist, limited to the mask width.
    localparam logic [MASK_W-1:0] TASK_MASK = (NUM_TASKS >= MASK_W) ? '1 :
        MASK_W'((64'd1 << NUM_TASKS) - 64'd1);

    typedef struct packed {
        logic               has_result;
        logic               feed_dog;
        logic               raise_error;
        logic [MASK_W-1:0]  late_tasks;
        logic [MASK_W-1:0]  next_checked;
        logic [COUNT_W-1:0] next_tick;
    } t_eval;

endpackage

FILE: rtl/core/tcw_if.sv
// Request and result channel interfaces of the task check-in watchdog.
interface tcw_in_if;
    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic [tcw_pkg::TASK_W-1:0] task_index;

    modport source (output valid, output opcode, output task_index, input ready);
    modport sink   (input valid, input opcode, input task_index, output ready);
endinterface

interface tcw_out_if;
    logic                      valid;
    logic                      ready;
    logic                      feed_dog;
    logic                      raise_error;
    logic [tcw_pkg::MASK_W-1:0] late_tasks;

    modport source (output valid, output feed_dog, output raise_error, output late_tasks,
                    input ready);
    modport sink   (input valid, input feed_dog, input raise_error, input late_tasks,
                    output ready);
endinterface

FILE: rtl/core/tcw_eval.sv
// Decision logic: result and next state for one request.
module tcw_eval (
    input  logic                        i_opcode,
    input  logic [tcw_pkg::TASK_W-1:0]  i_task_index,
    input  logic [tcw_pkg::MASK_W-1:0]  i_checked,
    input  logic [tcw_pkg::COUNT_W-1:0] i_tick,
    input  logic [tcw_pkg::COUNT_W-1:0] i_timeout,
    input  logic [tcw_pkg::MASK_W-1:0]  i_req_mask,
    output tcw_pkg::t_eval              o_eval
);
    import tcw_pkg::*;

    logic all_in;
    logic idx_ok;

    assign all_in = ((i_checked & i_req_mask) == i_req_mask);
    assign idx_ok = (32'(i_task_index) < NUM_TASKS);

    always_comb begin
        o_eval = '0;
        o_eval.next_checked = i_checked;
        o_eval.next_tick    = i_tick;
        if (i_opcode == OP_CHECKIN) begin
            if (idx_ok) begin
                o_eval.next_checked = i_checked | (MASK_W'(1) << i_task_index);
            end
        end else begin
            o_eval.has_result = 1'b1;
            if (all_in) begin
                o_eval.feed_dog     = 1'b1;
                o_eval.next_checked = '0;
                o_eval.next_tick    = '0;
            end else if (i_tick >= i_timeout) begin
                // Compare uses the count before the increment.
                o_eval.raise_error = 1'b1;
                o_eval.late_tasks  = ~i_checked & TASK_MASK;
                o_eval.next_tick   = '0;
            end else begin
                o_eval.next_tick = i_tick + COUNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/core/task_checkin_watchdog.sv
// Top level of the multi-task check-in watchdog.
// A request waits in the input register; each update is one 32-bit compare and add.
// Throughput: one request per cycle while no result is stalled on the result channel.
// Check-in requests produce no result and never wait on the result channel.
// Reset (i_rst_n low, synchronous) clears the mask, the tick count and both valids,
// loads the timeout with 0 and the required mask with all ones; no request is taken.
module task_checkin_watchdog (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tcw_in_if.sink                         i_req,
    tcw_out_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tcw_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tcw_pkg::*;

    // Input register: one request waits here while the state is evaluated.
    logic                r_in_valid;
    logic                r_in_opcode;
    logic [TASK_W-1:0]   r_in_task;

    // Watchdog state and configuration.
    logic [MASK_W-1:0]   r_checked_in;
    logic [COUNT_W-1:0]  r_tick;
    logic [COUNT_W-1:0]  r_timeout;
    logic [MASK_W-1:0]   r_req_mask;

    // Result register.
    logic                r_out_valid;
    logic                r_out_feed;
    logic                r_out_err;
    logic [MASK_W-1:0]   r_out_late;

    logic                n_in_valid;
    logic                n_out_valid;

    t_eval               ev;
    logic                out_free;
    logic                advance;
    logic                in_fire;
    logic                load;

    tcw_eval u_eval (
        .i_opcode     (r_in_opcode),
        .i_task_index (r_in_task),
        .i_checked    (r_checked_in),
        .i_tick       (r_tick),
        .i_timeout    (r_timeout),
        .i_req_mask   (r_req_mask),
        .o_eval       (ev)
    );

    // The result slot is free when empty or when its result leaves this cycle.
    // A check-in moves on regardless, since it produces nothing.
    assign out_free = !r_out_valid || o_rsp.ready;
    assign advance  = r_in_valid && (!ev.has_result || out_free);
    assign load     = advance && ev.has_result;

    assign i_req.ready = i_rst_n && (!r_in_valid || advance);
    assign in_fire     = i_req.valid && i_req.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_fire) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_checked_in <= '0;
            r_tick       <= '0;
            r_timeout    <= '0;
            r_req_mask   <= REQ_MASK_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_checked_in <= ev.next_checked;
                r_tick       <= ev.next_tick;
            end
            // The user must write configuration only while idle; it is not enforced.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TIMEOUT:  r_timeout  <= i_cfg_data;
                    CFG_REQ_MASK: r_req_mask <= i_cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_opcode <= i_req.opcode;
            r_in_task   <= i_req.task_index;
        end
        if (load) begin
            r_out_feed <= ev.feed_dog;
            r_out_err  <= ev.raise_error;
            r_out_late <= ev.late_tasks;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.feed_dog    = r_out_feed;
    assign o_rsp.raise_error = r_out_err;
    assign o_rsp.late_tasks  = r_out_late;

`include "task_checkin_watchdog_assert.svh"

    // A result never both feeds the dog and raises the error.
    `TCW_ASSERT_NOW(a_feed_err_excl, i_clk, i_rst_n, r_out_valid, !(r_out_feed && r_out_err))
    // Late tasks are reported only together with an error.
    `TCW_ASSERT_NOW(a_late_only_err, i_clk, i_rst_n, r_out_valid && !r_out_err,
                    r_out_late == '0)
    // Feeding the dog clears both the mask and the count.
    `TCW_ASSERT_NEXT(a_feed_clears, i_clk, i_rst_n, load && ev.feed_dog,
                     r_checked_in == '0 && r_tick == '0)
    // An error clears the count.
    `TCW_ASSERT_NEXT(a_err_clears, i_clk, i_rst_n, load && ev.raise_error, r_tick == '0)

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the task check-in watchdog: directed table, random rounds.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    // Roughly how many requests the random rounds send before the run winds down.
    localparam int TOTAL_REQUESTS = 1950;
    // The random part is split into segments.
    // Each segment has its own register setting; pairs of segments share an idling mix.
    localparam int SEGMENTS       = 8;
    // Cycles with no handshake on either channel before the run is declared hung.
    // The slowest correct run stalls for the pressure hold-off (HOLD_CYCLES).
    // Otherwise, gaps come only from random idling, at most 65 percent.
    localparam int QUIET_LIMIT    = 3000;
    localparam int HOLD_CYCLES    = 300;

    // The bits of the tasks that exist. With 16 tasks and a 16-bit mask this is all ones.
    localparam logic [MASK_W-1:0] LIVE_TASKS =
        (NUM_TASKS >= MASK_W) ? '1 : MASK_W'((64'd1 << NUM_TASKS) - 64'd1);

    typedef struct packed {
        logic              feed_dog;
        logic              raise_error;
        logic [MASK_W-1:0] late_tasks;
    } t_dog_verdict;

    typedef enum logic {ROW_REQUEST, ROW_WRITE} t_row_kind;

    // One row of the directed table.
    // A write row loads a register.
    // A request row sends one request. When "pinned" is set, the expected verdict is
    // the one typed in the row. Otherwise it comes from the predictor.
    typedef struct packed {
        t_row_kind              kind;
        logic                   opcode;
        logic [TASK_W-1:0]      task_index;
        logic [CFG_IDX_W-1:0]   reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        logic                   pinned;
        logic                   feed_dog;
        logic                   raise_error;
        logic [MASK_W-1:0]      late_tasks;
    } t_stim_row;

    localparam int DIRECTED_LEN = 23;
    localparam t_stim_row DIRECTED_ROWS [DIRECTED_LEN] = '{
        // Out of reset: timeout 0 and nobody checked in, so the first step errors.
        '{ROW_REQUEST, OP_PROCESS, 4'h0, CFG_TIMEOUT,  32'h0, 1'b1, 1'b0, 1'b1, 16'hFFFF},
        // Lowest and highest task index.
        '{ROW_REQUEST, OP_CHECKIN, 4'h0, CFG_TIMEOUT,  32'h0, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{ROW_REQUEST, OP_CHECKIN, 4'hF, CFG_TIMEOUT,  32'h0, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{ROW_REQUEST, OP_PROCESS, 4'hF, CFG_TIMEOUT,  32'h0, 1'b1, 1'b0, 1'b1, 16'h7FFE},
        // The error left both bits set, so a mask of just those two feeds the dog.
        '{ROW_WRITE,   OP_CHECKIN, 4'h0, CFG_REQ_MASK, 32'h8001, 1'b0, 1'b0, 1'b0, 16'h0},
        '{ROW_REQUEST, OP_PROCESS, 4'hA, CFG_TIMEOUT,  32'h0, 1'b1, 1'b1, 1'b0, 16'h0000},
        // With an empty required mask, every step feeds the dog.
        '{ROW_WRITE,   OP_CHECKIN, 4'h0, CFG_REQ_MASK, 32'h0, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{ROW_REQUEST, OP_PROCESS, 4'h5, CFG_TIMEOUT,  32'h0, 1'b1, 1'b1, 1'b0, 16'h0000},
        // Largest timeout: steps only count.
        '{ROW_WRITE,   OP_CHECKIN, 4'h0, CFG_TIMEOUT,  32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 16'h0},
        '{ROW_WRITE,   OP_CHECKIN, 4'h0, CFG_REQ_MASK, 32'hFFFF, 1'b0, 1'b0, 1'b0, 16'h0},
        '{ROW_REQUEST, OP_PROCESS, 4'h3, CFG_TIMEOUT,  32'h0, 1'b1, 1'b0, 1'b0, 16'h0000},
        '{ROW_REQUEST, OP_PROCESS, 4'hC, CFG_TIMEOUT,  32'h0, 1'b1, 1'b0, 1'b0, 16'h0000},
        // Timeout dropped below the count.
        // The compare is "at least", so the next step still errors.
        '{ROW_WRITE,   OP_CHECKIN, 4'h0, CFG_TIMEOUT,  32'h1, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{ROW_REQUEST, OP_PROCESS, 4'h0, CFG_TIMEOUT,  32'h0, 1'b1, 1'b0, 1'b1, 16'hFFFF},
        '{ROW_REQUEST, OP_CHECKIN, 4'h5, CFG_TIMEOUT,  32'h0, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{ROW_REQUEST, OP_PROCESS, 4'h9, CFG_TIMEOUT,  32'h0, 1'b1, 1'b0, 1'b0, 16'h0000},
        '{ROW_REQUEST, OP_PROCESS, 4'h6, CFG_TIMEOUT,  32'h0, 1'b1, 1'b0, 1'b1, 16'hFFDF},
        // The rest follow the predictor.
        '{ROW_WRITE,   OP_CHECKIN, 4'h0, CFG_TIMEOUT,  32'h2, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{ROW_REQUEST, OP_CHECKIN, 4'h7, CFG_TIMEOUT,  32'h0, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{ROW_REQUEST, OP_CHECKIN, 4'hA, CFG_TIMEOUT,  32'h0, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{ROW_REQUEST, OP_PROCESS, 4'hB, CFG_TIMEOUT,  32'h0, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{ROW_WRITE,   OP_CHECKIN, 4'h0, CFG_REQ_MASK, 32'h04A0, 1'b0, 1'b0, 1'b0, 16'h0},
        '{ROW_REQUEST, OP_PROCESS, 4'hE, CFG_TIMEOUT,  32'h0, 1'b0, 1'b0, 1'b0, 16'h0000}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tcw_in_if  req_if ();
    tcw_out_if rsp_if ();

    task_checkin_watchdog DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // This is the testbench's own copy of the watchdog state and its registers.
    logic [COUNT_W-1:0]  timeout_model;
    logic [MASK_W-1:0]   required_model;
    logic [MASK_W-1:0]   checked_model;
    logic [COUNT_W-1:0]  tick_model;

    t_dog_verdict        pending_verdicts[$];
    int                  requests_taken   = 0;
    int                  requests_sent    = 0;
    int                  mismatches       = 0;
    int                  quiet_cycles     = 0;
    int                  sender_idle_pct  = 0;
    int                  receiver_stall_pct = 0;
    int                  hold_left        = 0;

    // A directed row can pin its expected verdict.
    // The scoreboard picks the pin up together with the request.
    bit                  pin_active = 1'b0;
    t_dog_verdict        pin_verdict = '0;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t ns] mismatch: %s", $realtime, what);
    endtask

    // Apply one request to the state copy.
    // A check-in only sets a bit. A process step always yields a verdict.
    // The verdict is one of three: feed when every required task has checked in,
    // raise the error when the old tick count has reached the timeout,
    // or nothing at all.
    function automatic void advance_watchdog(input logic op, input logic [TASK_W-1:0] index,
                                             output bit has_verdict,
                                             output t_dog_verdict verdict);
        logic [COUNT_W-1:0] previous_ticks;
        verdict     = '0;
        has_verdict = 1'b0;
        if (op == OP_CHECKIN) begin
            if (int'(index) < NUM_TASKS)
                checked_model[index] = 1'b1;
        end else begin
            has_verdict = 1'b1;
            if ((checked_model & required_model) == required_model) begin
                checked_model    = '0;
                tick_model       = '0;
                verdict.feed_dog = 1'b1;
            end else begin
                previous_ticks = tick_model;
                tick_model     = tick_model + 1'b1;
                // After an error the count restarts, but the check-in bits are kept.
                if (previous_ticks >= timeout_model) begin
                    tick_model          = '0;
                    verdict.raise_error = 1'b1;
                    verdict.late_tasks  = ~checked_model & LIVE_TASKS;
                end
            end
        end
    endfunction

    // Scoreboard, sampled at the rising edge.
    // Results are retired first. A result at this edge always belongs to a request
    // accepted at an earlier edge.
    always @(posedge i_clk) begin : scoreboard
        t_dog_verdict predicted;
        t_dog_verdict wanted;
        bit           has_verdict;
        if (i_rst_n === 1'b1) begin
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                if (pending_verdicts.size() == 0) begin
                    report_mismatch($sformatf("unexpected result feed=%b error=%b late=%h",
                        rsp_if.feed_dog, rsp_if.raise_error, rsp_if.late_tasks));
                end else begin
                    wanted = pending_verdicts.pop_front();
                    if (rsp_if.feed_dog !== wanted.feed_dog)
                        report_mismatch($sformatf("feed_dog got %b want %b",
                            rsp_if.feed_dog, wanted.feed_dog));
                    if (rsp_if.raise_error !== wanted.raise_error)
                        report_mismatch($sformatf("raise_error got %b want %b",
                            rsp_if.raise_error, wanted.raise_error));
                    if (rsp_if.late_tasks !== wanted.late_tasks)
                        report_mismatch($sformatf("late_tasks got %h want %h",
                            rsp_if.late_tasks, wanted.late_tasks));
                end
            end
            if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
                advance_watchdog(req_if.opcode, req_if.task_index, has_verdict, predicted);
                if (has_verdict)
                    pending_verdicts.push_back(pin_active ? pin_verdict : predicted);
                requests_taken++;
            end
        end
    end

    // The run is declared hung when the quiet counter, cleared by any handshake or by reset, reaches QUIET_LIMIT.
    always @(posedge i_clk) begin : hang_guard
        if (i_rst_n !== 1'b1 || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("task_checkin_watchdog verification failed");
            $finish;
        end
    end

    // The receiver changes ready at the falling edge.
    // A hold-off request keeps ready low for that many cycles, counted here. Outside a
    // hold-off, ready drops at random at the current stall rate.
    initial begin : receiver
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Offer one request and return at the falling edge right after it was taken.
    // The caller must drive valid again at that same edge.
    // Either the next request is sent at once, or valid is lowered.
    // Idle gaps are inserted first at the current idle rate.
    task automatic send_request(input logic op, input logic [TASK_W-1:0] index,
                                input bit pinned, input t_dog_verdict verdict);
        int taken_before;
        while ($urandom_range(99) < sender_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.opcode     <= op;
        req_if.task_index <= index;
        pin_active         = pinned;
        pin_verdict        = verdict;
        taken_before       = requests_taken;
        do begin
            @(negedge i_clk);
        end while (requests_taken == taken_before);
        requests_sent++;
    endtask

    // Registers change only while the block is quiet.
    // First lower valid and let every pending result drain.
    // Then let a check-in that is still settling finish.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        req_if.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= index;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == CFG_TIMEOUT)
            timeout_model = value;
        else
            required_model = value[MASK_W-1:0];
    endtask

    // A well-formed round checks in most of the required tasks and a few stray ones.
    // It then runs one to three process steps.
    // Missing bits carry over to later rounds, so feeds, errors and plain ticks all occur.
    task automatic run_round();
        for (int t = 0; t < NUM_TASKS; t++)
            if (required_model[t] && $urandom_range(99) < 88)
                send_request(OP_CHECKIN, TASK_W'(t), 1'b0, '0);
        repeat ($urandom_range(2))
            send_request(OP_CHECKIN, TASK_W'($urandom_range(15)), 1'b0, '0);
        repeat ($urandom_range(1, 3))
            send_request(OP_PROCESS, TASK_W'($urandom_range(15)), 1'b0, '0);
    endtask

    // Noise is a short burst of requests with random opcode and random index.
    task automatic run_noise();
        repeat ($urandom_range(1, 8))
            send_request($urandom_range(1) ? OP_PROCESS : OP_CHECKIN,
                         TASK_W'($urandom_range(15)), 1'b0, '0);
    endtask

    initial begin : stimulus
        t_stim_row             row;
        logic [CFG_DATA_W-1:0] new_timeout;
        logic [MASK_W-1:0]     new_mask;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_TIMEOUT;
        i_cfg_data        = '0;
        req_if.valid      = 1'b0;
        req_if.opcode     = OP_CHECKIN;
        req_if.task_index = '0;
        timeout_model     = '0;
        required_model    = '1;
        checked_model     = '0;
        tick_model        = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: walk the table in order.
        for (int n = 0; n < DIRECTED_LEN; n++) begin
            row = DIRECTED_ROWS[n];
            if (row.kind == ROW_WRITE)
                write_register(row.reg_index, row.reg_value);
            else
                send_request(row.opcode, row.task_index, row.pinned,
                             '{row.feed_dog, row.raise_error, row.late_tasks});
        end

        // Random part. Each pair of segments shares an idling mix:
        // no idling, then sender idle, then receiver stalling, then both at once.
        // Every segment starts with a fresh register setting.
        // The extremes (timeout 0 and all ones, mask 0 and all ones) come up in turn.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 2)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 65; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 65; end
                default: begin sender_idle_pct = 29; receiver_stall_pct = 29; end
            endcase
            case (seg % 4)
                0: new_timeout = '0;
                1: new_timeout = '1;
                2: new_timeout = CFG_DATA_W'($urandom_range(1, 6));
                default: new_timeout = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom) :
                                       CFG_DATA_W'($urandom_range(2, 12));
            endcase
            case ((seg + 1) % 4)
                0: new_mask = '0;
                1: new_mask = '1;
                2: new_mask = MASK_W'(1) << $urandom_range(MASK_W - 1);
                default: new_mask = MASK_W'($urandom_range(16'hFFFF));
            endcase
            write_register(CFG_TIMEOUT, new_timeout);
            write_register(CFG_REQ_MASK, new_mask);

            // Back-pressure: the receiver holds ready low for a long stretch.
            // The sender keeps offering requests meanwhile.
            // The result register fills, and process requests back up on the input.
            if (seg == 0)
                hold_left = HOLD_CYCLES;

            while (requests_sent < DIRECTED_LEN + (seg + 1) * TOTAL_REQUESTS / SEGMENTS) begin
                if ($urandom_range(99) < 75)
                    run_round();
                else
                    run_noise();
            end
        end

        // Drain: wait for every expected verdict, then for any stray result.
        req_if.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);

        if (mismatches == 0)
            $display("task_checkin_watchdog verification clean");
        else
            $display("task_checkin_watchdog verification failed");
        $finish;
    end

endmodule

FILE: task_checkin_watchdog.f
+incdir+rtl/core
rtl/core/tcw_pkg.sv
rtl/core/tcw_if.sv
rtl/core/tcw_eval.sv
rtl/core/task_checkin_watchdog.sv
dv/testbench.sv
